>>> sv/wfv_pkg.sv
// Package for the log-law wall function block: Q16.32 constants, register
// indexes, and the request and response types of the shared arithmetic unit.
// No dependencies.
package wfv_pkg;

    localparam int QW = 48;
    localparam logic [QW-1:0] QMASK = 48'hFFFF_FFFF_FFFF;
    localparam logic [QW-1:0] QONE = 48'h0001_0000_0000;
    localparam logic [QW-1:0] CONV_TOL = 48'd42949673;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam int LNW = 42;
    localparam logic signed [LNW-1:0] LN_OF_ZERO = -(42'sd1 <<< 40);

    localparam int MAX_ITERATIONS = 10;
    localparam int ITER_W = $clog2(MAX_ITERATIONS + 1);

    localparam logic [QW-1:0] KAPPA_RST = 48'd1760936591;
    localparam logic [QW-1:0] E_RST = 48'd42090679501;
    localparam logic [QW-1:0] YPLAM_RST = 48'd49520972923;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_KAPPA = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_E = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YPLAM = 2'd2;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_LN
    } alu_op_t;

    typedef struct packed {
        logic          start;
        alu_op_t       op;
        logic [QW-1:0] a;
        logic [QW-1:0] b;
    } alu_req_t;

    typedef struct packed {
        logic                  done;
        logic [QW-1:0]         res;
        logic signed [LNW-1:0] ln;
    } alu_rsp_t;

endpackage

>>> sv/wall_function_turbulent_viscosity.sv
// Top level of the log-law wall function: configuration registers, stream
// ports and the sequencer that drives the shared arithmetic unit.
// Depends on wfv_pkg and wfv_alu.

// One wall face is a transfer of four Q16.32 values; the block answers with
// y+ and the turbulent viscosity after the whole fixed-point iteration, and
// takes no new transfer until the result has been taken. Every operation runs
// on one shared unit, which answers a logarithm of zero or a division by zero
// without running its bit-serial steps. A face takes a set-up, as many passes
// of the iteration as are needed (at most ten), and a viscosity tail where one
// applies, plus any wait on the output.
module wall_function_turbulent_viscosity
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [47:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // velocity_magnitude, wall_distance, wall_density, wall_viscosity
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // y_plus, turbulent_viscosity
    output logic [95:0]  m_tdata
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_K1,
        ST_K2,
        ST_K3,
        ST_K4,
        ST_RLAM,
        ST_L_MUL,
        ST_L_LN,
        ST_L_DIV,
        ST_L_CHK,
        ST_F_MUL,
        ST_F_LN,
        ST_F_MULK,
        ST_F_DIV,
        ST_F_MU,
        ST_OUT
    } seq_state_t;

    seq_state_t state_reg;
    logic pend_reg;
    logic [47:0] kappa_reg;
    logic [47:0] e_reg;
    logic [47:0] lam_reg;
    logic [47:0] u_reg;
    logic [47:0] y_reg;
    logic [47:0] rho_reg;
    logic [47:0] mu_reg;
    logic [47:0] t_reg;
    logic [47:0] kre_reg;
    logic [47:0] rlam_reg;
    logic [47:0] yp_reg;
    logic [47:0] d_reg;
    logic [47:0] mut_reg;
    logic [wfv_pkg::ITER_W-1:0] iter_reg;

    wfv_pkg::alu_req_t req;
    wfv_pkg::alu_rsp_t rsp;

    wfv_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kappa_reg <= wfv_pkg::KAPPA_RST;
            e_reg <= wfv_pkg::E_RST;
            lam_reg <= wfv_pkg::YPLAM_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                wfv_pkg::CFG_KAPPA: kappa_reg <= cfg_data;
                wfv_pkg::CFG_E:     e_reg <= cfg_data;
                wfv_pkg::CFG_YPLAM: lam_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Operation requested of the shared unit in each step.
    always_comb
    begin
        req.start = 1'b0;
        req.op = wfv_pkg::OP_MUL;
        req.a = '0;
        req.b = '0;
        unique case (state_reg)
            ST_K1:     begin req.a = kappa_reg; req.b = u_reg; end
            ST_K2:     begin req.a = t_reg; req.b = y_reg; end
            ST_K3:     begin req.a = t_reg; req.b = rho_reg; end
            ST_K4:     begin req.op = wfv_pkg::OP_DIV; req.a = t_reg; req.b = mu_reg; end
            ST_RLAM:   begin req.op = wfv_pkg::OP_DIV; req.a = wfv_pkg::QONE; req.b = lam_reg; end
            ST_L_MUL:  begin req.a = e_reg; req.b = yp_reg; end
            ST_L_LN:   begin req.op = wfv_pkg::OP_LN; req.a = t_reg; end
            ST_L_DIV:  begin req.op = wfv_pkg::OP_DIV; req.a = t_reg; req.b = d_reg; end
            ST_L_CHK:  begin req.a = rlam_reg; req.b = t_reg; end
            ST_F_MUL:  begin req.a = e_reg; req.b = yp_reg; end
            ST_F_LN:   begin req.op = wfv_pkg::OP_LN; req.a = t_reg; end
            ST_F_MULK: begin req.a = yp_reg; req.b = kappa_reg; end
            ST_F_DIV:  begin req.op = wfv_pkg::OP_DIV; req.a = t_reg; req.b = d_reg; end
            ST_F_MU:   begin req.a = mu_reg; req.b = t_reg; end
            default:   ;
        endcase
        req.start = (state_reg != ST_IDLE) && (state_reg != ST_OUT) && !pend_reg;
    end

    // Denominator 1 + ln, the saturating numerator, the positive-log test and the step difference.
    logic signed [42:0] dsum;
    logic [47:0] dval;
    logic [48:0] num_sum;
    logic [47:0] num_val;
    logic ln_pos;
    logic [47:0] ln_val;
    logic [47:0] diff_val;
    always_comb
    begin
        dsum = 43'sd4294967296 + {rsp.ln[41], rsp.ln};
        dval = (dsum < 43'sd1) ? 48'd1 : {5'b0, dsum};
        num_sum = {1'b0, kre_reg} + {1'b0, yp_reg};
        num_val = num_sum[48] ? wfv_pkg::QMASK : num_sum[47:0];
        ln_pos = !rsp.ln[41] && (rsp.ln != '0);
        ln_val = {6'b0, rsp.ln};
        diff_val = (rsp.res > yp_reg) ? (rsp.res - yp_reg) : (yp_reg - rsp.res);
    end

    // Sequencer of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            if (req.start)
            begin
                pend_reg <= 1'b1;
            end
            if (rsp.done)
            begin
                pend_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        u_reg <= s_tdata[47:0];
                        y_reg <= s_tdata[95:48];
                        rho_reg <= s_tdata[143:96];
                        mu_reg <= s_tdata[191:144];
                        state_reg <= ST_K1;
                    end
                end
                ST_K1:
                begin
                    if (rsp.done) begin t_reg <= rsp.res; state_reg <= ST_K2; end
                end
                ST_K2:
                begin
                    if (rsp.done) begin t_reg <= rsp.res; state_reg <= ST_K3; end
                end
                ST_K3:
                begin
                    if (rsp.done) begin t_reg <= rsp.res; state_reg <= ST_K4; end
                end
                ST_K4:
                begin
                    if (rsp.done) begin kre_reg <= rsp.res; state_reg <= ST_RLAM; end
                end
                ST_RLAM:
                begin
                    if (rsp.done)
                    begin
                        rlam_reg <= rsp.res;
                        yp_reg <= lam_reg;
                        iter_reg <= '0;
                        state_reg <= ST_L_MUL;
                    end
                end
                ST_L_MUL:
                begin
                    if (rsp.done) begin t_reg <= rsp.res; state_reg <= ST_L_LN; end
                end
                ST_L_LN:
                begin
                    if (rsp.done)
                    begin
                        d_reg <= dval;
                        t_reg <= num_val;
                        state_reg <= ST_L_DIV;
                    end
                end
                ST_L_DIV:
                begin
                    if (rsp.done)
                    begin
                        yp_reg <= rsp.res;
                        t_reg <= diff_val;
                        state_reg <= ST_L_CHK;
                    end
                end
                ST_L_CHK:
                begin
                    if (rsp.done)
                    begin
                        if (rsp.res <= wfv_pkg::CONV_TOL ||
                            iter_reg + 1'b1 >= wfv_pkg::ITER_W'(wfv_pkg::MAX_ITERATIONS))
                        begin
                            mut_reg <= '0;
                            state_reg <= (yp_reg > lam_reg) ? ST_F_MUL : ST_OUT;
                        end
                        else
                        begin
                            iter_reg <= iter_reg + 1'b1;
                            state_reg <= ST_L_MUL;
                        end
                    end
                end
                ST_F_MUL:
                begin
                    if (rsp.done) begin t_reg <= rsp.res; state_reg <= ST_F_LN; end
                end
                ST_F_LN:
                begin
                    if (rsp.done)
                    begin
                        d_reg <= ln_val;
                        state_reg <= ln_pos ? ST_F_MULK : ST_OUT;
                    end
                end
                ST_F_MULK:
                begin
                    if (rsp.done) begin t_reg <= rsp.res; state_reg <= ST_F_DIV; end
                end
                ST_F_DIV:
                begin
                    if (rsp.done)
                    begin
                        t_reg <= rsp.res - wfv_pkg::QONE;
                        state_reg <= (rsp.res > wfv_pkg::QONE) ? ST_F_MU : ST_OUT;
                    end
                end
                ST_F_MU:
                begin
                    if (rsp.done) begin mut_reg <= rsp.res; state_reg <= ST_OUT; end
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = state_reg == ST_OUT;
    assign m_tdata = {mut_reg, yp_reg};

endmodule

>>> sv/wfv_alu.sv
// Shared arithmetic unit: saturating Q16.32 multiply and bit-serial natural
// logarithm around one registered 32x32 multiplier, and a bit-serial divide.
// Depends on wfv_pkg.
module wfv_alu
(
    input  logic              clk,
    input  logic              rst_n,
    input  wfv_pkg::alu_req_t req,
    output wfv_pkg::alu_rsp_t rsp
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_MUL,
        A_DIV,
        A_NORM,
        A_SQ,
        A_LNMUL,
        A_LNFIN
    } alu_state_t;

    alu_state_t state_reg;
    logic [6:0] cnt_reg;
    logic [47:0] a_reg;
    logic [47:0] b_reg;
    logic [49:0] acc_reg;
    logic sat_reg;
    logic [47:0] rem_reg;
    logic [47:0] q_reg;
    logic [47:0] x_reg;
    logic [5:0] p_reg;
    logic [30:0] m_reg;
    logic [31:0] frac_reg;
    logic phase_reg;
    logic [37:0] mag_reg;
    logic neg_reg;
    logic done_reg;
    logic [47:0] res_reg;
    logic signed [41:0] ln_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod_reg;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            A_MUL:
            begin
                unique case (cnt_reg[1:0])
                    2'd0:
                    begin
                        mul_a = {16'b0, a_reg[47:32]};
                        mul_b = {16'b0, b_reg[47:32]};
                    end
                    2'd1:
                    begin
                        mul_a = {16'b0, a_reg[47:32]};
                        mul_b = b_reg[31:0];
                    end
                    2'd2:
                    begin
                        mul_a = a_reg[31:0];
                        mul_b = {16'b0, b_reg[47:32]};
                    end
                    default:
                    begin
                        mul_a = a_reg[31:0];
                        mul_b = b_reg[31:0];
                    end
                endcase
            end
            A_SQ:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            A_LNMUL:
            begin
                mul_a = mag_reg[31:0];
                mul_b = wfv_pkg::LN2_Q32;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Divider step: one quotient bit per cycle.
    logic [48:0] div_r2;
    logic div_ge;
    logic [48:0] div_diff;
    always_comb
    begin
        div_r2 = {rem_reg, x_reg[47]};
        div_ge = div_r2 >= {1'b0, b_reg};
        div_diff = div_r2 - {1'b0, b_reg};
    end

    // Normalising step: shift by 32, 16, 8, 4, 2 and then 1 place.
    logic [5:0] norm_s;
    logic norm_zero;
    logic [47:0] norm_x;
    logic [5:0] norm_p;
    always_comb
    begin
        norm_s = 6'd32 >> cnt_reg[2:0];
        norm_zero = (x_reg >> (6'd48 - norm_s)) == 48'd0;
        norm_x = norm_zero ? (x_reg << norm_s) : x_reg;
        norm_p = norm_zero ? (p_reg - norm_s) : p_reg;
    end

    // Squaring step: one fraction bit of log2 per squaring.
    logic [31:0] sq;
    logic [30:0] sq_m;
    logic [31:0] sq_frac;
    always_comb
    begin
        sq = prod_reg[61:30];
        sq_m = sq[31] ? sq[31:1] : sq[30:0];
        sq_frac = {frac_reg[30:0], sq[31]};
    end

    // Final sums of the multiply and the logarithm.
    logic [49:0] mul_sum;
    logic [38:0] ln_mag;
    always_comb
    begin
        mul_sum = acc_reg + {18'b0, prod_reg[63:32]};
        ln_mag = 39'(mag_reg[37:32]) * 39'(wfv_pkg::LN2_Q32) + {7'b0, prod_reg[63:32]};
    end

    // Sequencer of the unit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                A_IDLE:
                begin
                    if (req.start)
                    begin
                        a_reg <= req.a;
                        b_reg <= req.b;
                        cnt_reg <= '0;
                        sat_reg <= 1'b0;
                        unique case (req.op)
                            wfv_pkg::OP_MUL:
                            begin
                                state_reg <= A_MUL;
                            end
                            wfv_pkg::OP_DIV:
                            begin
                                if (req.b == 48'd0)
                                begin
                                    res_reg <= (req.a == 48'd0) ? 48'd0 : wfv_pkg::QMASK;
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    rem_reg <= '0;
                                    q_reg <= '0;
                                    x_reg <= req.a;
                                    state_reg <= A_DIV;
                                end
                            end
                            default:
                            begin
                                if (req.a == 48'd0)
                                begin
                                    ln_reg <= wfv_pkg::LN_OF_ZERO;
                                    done_reg <= 1'b1;
                                end
                                else
                                begin
                                    x_reg <= req.a;
                                    p_reg <= 6'd47;
                                    state_reg <= A_NORM;
                                end
                            end
                        endcase
                    end
                end
                A_MUL:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd1)
                    begin
                        sat_reg <= prod_reg[63:16] != 48'd0;
                        acc_reg <= {2'b0, prod_reg[15:0], 32'b0};
                    end
                    else if (cnt_reg == 7'd2 || cnt_reg == 7'd3)
                    begin
                        acc_reg <= acc_reg + {2'b0, prod_reg[47:0]};
                    end
                    else if (cnt_reg == 7'd4)
                    begin
                        res_reg <= (sat_reg || mul_sum[49:48] != 2'b0) ?
                                   wfv_pkg::QMASK : mul_sum[47:0];
                        done_reg <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                A_DIV:
                begin
                    rem_reg <= div_ge ? div_diff[47:0] : div_r2[47:0];
                    x_reg <= {x_reg[46:0], 1'b0};
                    q_reg <= {q_reg[46:0], div_ge};
                    sat_reg <= sat_reg | q_reg[47];
                    cnt_reg <= cnt_reg + 7'd1;
                    if (cnt_reg == 7'd79)
                    begin
                        res_reg <= (sat_reg || q_reg[47]) ? wfv_pkg::QMASK
                                                           : {q_reg[46:0], div_ge};
                        done_reg <= 1'b1;
                        state_reg <= A_IDLE;
                    end
                end
                A_NORM:
                begin
                    x_reg <= norm_x;
                    p_reg <= norm_p;
                    if (cnt_reg == 7'd5)
                    begin
                        m_reg <= norm_x[47:17];
                        cnt_reg <= '0;
                        phase_reg <= 1'b0;
                        frac_reg <= '0;
                        state_reg <= A_SQ;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 7'd1;
                    end
                end
                A_SQ:
                begin
                    phase_reg <= ~phase_reg;
                    if (phase_reg)
                    begin
                        m_reg <= sq_m;
                        frac_reg <= sq_frac;
                        cnt_reg <= cnt_reg + 7'd1;
                        if (cnt_reg == 7'd31)
                        begin
                            neg_reg <= p_reg < 6'd32;
                            if (p_reg >= 6'd32)
                            begin
                                mag_reg <= {p_reg - 6'd32, sq_frac};
                            end
                            else
                            begin
                                mag_reg <= {6'd32 - p_reg, 32'b0} - {6'b0, sq_frac};
                            end
                            state_reg <= A_LNMUL;
                        end
                    end
                end
                A_LNMUL:
                begin
                    state_reg <= A_LNFIN;
                end
                A_LNFIN:
                begin
                    ln_reg <= neg_reg ? -$signed({3'b0, ln_mag}) : $signed({3'b0, ln_mag});
                    done_reg <= 1'b1;
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.res = res_reg;
    assign rsp.ln = ln_reg;

endmodule

>>> sim/wall_function_turbulent_viscosity_tb.sv
// Self-checking testbench for the log-law wall function block.
// Drives wall faces over the input stream, predicts y+ and turbulent viscosity
// in Q16.32, and checks every output transfer. Depends on wfv_pkg and the RTL.
module wall_function_turbulent_viscosity_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1050;
    localparam longint CYCLE_LIMIT = 64'd12_000_000;
    localparam int DRAIN_CYCLES = 3000;
    localparam logic [47:0] FULL = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] QONE = wfv_pkg::QONE;

    typedef struct {
        logic [47:0] u;
        logic [47:0] y;
        logic [47:0] rho;
        logic [47:0] mu;
        logic        known;
        logic [47:0] yp_exp;
        logic [47:0] mut_exp;
    } face_row_t;

    logic         clk;
    logic         rst_n;
    logic         cfg_wr_en;
    logic [1:0]   cfg_index;
    logic [47:0]  cfg_data;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;

    // Local copy of the configuration registers.
    logic [47:0] kappa_q;
    logic [47:0] e_q;
    logic [47:0] yplam_q;

    // Expected y+ and viscosity, oldest first.
    logic [95:0] wall_results_q[$];

    int     mismatches;
    int     fails;
    longint cycles;
    bit     quiet_stretch;

    wall_function_turbulent_viscosity dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Q16.32 multiply, truncated and saturating.
    function automatic logic [47:0] q_mul(logic [47:0] a, logic [47:0] b);
        logic [95:0] p;
        p = (96'(a) * 96'(b)) >> 32;
        return (p > 96'(FULL)) ? FULL : p[47:0];
    endfunction

    // Q16.32 divide, floor, saturating; zero divisor per the special case.
    function automatic logic [47:0] q_div(logic [47:0] a, logic [47:0] b);
        logic [95:0] q;
        if (b == 0)
            return (a == 0) ? 48'd0 : FULL;
        q = (96'(a) << 32) / 96'(b);
        return (q > 96'(FULL)) ? FULL : q[47:0];
    endfunction

    // Natural log in Q32, signed, by bitwise log2 and a fixed ln2 scale.
    function automatic longint q_ln(logic [47:0] x);
        int          msb;
        logic [63:0] m;
        logic [63:0] frac;
        logic [63:0] mag;
        logic [63:0] lnmag;
        logic [127:0] sq;
        msb = 47;
        frac = 0;
        if (x == 0)
            return -(64'sd1 <<< 40);
        while (x[msb] == 1'b0)
            msb--;
        m = (msb >= 30) ? 64'(x) >> (msb - 30) : 64'(x) << (30 - msb);
        for (int i = 0; i < 32; i++)
        begin
            sq = 128'(m) * 128'(m);
            m = 64'(sq >> 30);
            frac = frac << 1;
            if (m >= (64'd2 << 30))
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        if (msb >= 32)
            mag = (64'(msb - 32) << 32) + frac;
        else
            mag = (64'(32 - msb) << 32) - frac;
        lnmag = (mag >> 32) * 64'(wfv_pkg::LN2_Q32) +
                (((mag & 64'hFFFF_FFFF) * 64'(wfv_pkg::LN2_Q32)) >> 32);
        return (msb >= 32) ? longint'(lnmag) : -longint'(lnmag);
    endfunction

    // Predicts {turbulent viscosity, y+} for one wall face.
    function automatic logic [95:0] predict_wall_face(logic [47:0] u, logic [47:0] y,
                                                      logic [47:0] rho, logic [47:0] mu);
        logic [47:0] kre;
        logic [47:0] rlam;
        logic [47:0] yp;
        logic [47:0] last;
        logic [47:0] num;
        logic [47:0] diff;
        logic [47:0] mut;
        logic [47:0] q;
        logic [48:0] sum;
        longint      ln;
        longint      d;
        int          passes;
        mut = 0;
        passes = 0;
        kre = q_div(q_mul(q_mul(q_mul(kappa_q, u), y), rho), mu);
        rlam = q_div(QONE, yplam_q);
        yp = yplam_q;
        forever
        begin
            last = yp;
            ln = q_ln(q_mul(e_q, yp));
            d = longint'(QONE) + ln;
            if (d < 1)
                d = 1;
            sum = 49'(kre) + 49'(yp);
            num = sum[48] ? FULL : sum[47:0];
            yp = q_div(num, d[47:0]);
            diff = (yp > last) ? yp - last : last - yp;
            if (q_mul(rlam, diff) <= wfv_pkg::CONV_TOL)
                break;
            passes++;
            if (passes >= wfv_pkg::MAX_ITERATIONS)
                break;
        end
        // Viscosity only above the laminar limit and for a positive log.
        if (yp > yplam_q)
        begin
            ln = q_ln(q_mul(e_q, yp));
            if (ln > 0)
            begin
                q = q_div(q_mul(yp, kappa_q), ln[47:0]);
                if (q > QONE)
                    mut = q_mul(mu, q - QONE);
            end
        end
        return {mut, yp};
    endfunction

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Mostly physical magnitudes, sometimes anything at all.
    function automatic logic [47:0] rand_field(bit nonzero);
        logic [47:0] v;
        case ($urandom_range(0, 9))
            0: v = rand48();
            1: v = rand48() >> $urandom_range(0, 47);
            default: v = {16'($urandom_range(0, 40)), 32'($urandom)};
        endcase
        if (nonzero && v == 0)
            v = 48'd1;
        return v;
    endfunction

    // One register write, with the write port then left idle before the task returns.
    task automatic write_reg(logic [1:0] idx, logic [47:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            wfv_pkg::CFG_KAPPA: kappa_q = val;
            wfv_pkg::CFG_E:     e_q = val;
            default:            yplam_q = val;
        endcase
        @(posedge clk);
    endtask

    // Waits for all outstanding results, then a short settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (wall_results_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // One input transfer, sometimes with a random gap before it; valid stays high
    // after the transfer until the next gap or the next idle wait.
    task automatic send_face(logic [47:0] u, logic [47:0] y, logic [47:0] rho,
                             logic [47:0] mu, logic [95:0] exp_res, bit use_table);
        logic [95:0] pred;
        if (!quiet_stretch && $urandom_range(0, 99) < 27)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pred = predict_wall_face(u, y, rho, mu);
        if (use_table && pred !== exp_res)
        begin
            fails++;
            $display("table row disagrees with prediction: %h vs %h", exp_res, pred);
        end
        wall_results_q.push_back(use_table ? exp_res : pred);
        s_tvalid <= 1'b1;
        s_tdata <= {mu, rho, y, u};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Output side: random back-pressure and field checks.
    always @(posedge clk)
    begin
        logic [95:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (wall_results_q.size() == 0)
                begin
                    fails++;
                    if (mismatches < 10)
                        $display("unexpected result transfer %h", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = wall_results_q.pop_front();
                    if (m_tdata[47:0] !== want[47:0] || m_tdata[95:48] !== want[95:48])
                    begin
                        fails++;
                        if (mismatches < 10)
                            $display("mismatch: y_plus exp %h got %h, mu_t exp %h got %h",
                                     want[47:0], m_tdata[47:0], want[95:48], m_tdata[95:48]);
                        mismatches++;
                    end
                end
            end
            m_tready <= quiet_stretch || ($urandom_range(0, 99) >= 27);
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        face_row_t rows[$];
        face_row_t r;
        logic [47:0] u;
        logic [47:0] y;
        fails = 0;
        mismatches = 0;
        cycles = 0;
        quiet_stretch = 1'b0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        kappa_q = wfv_pkg::KAPPA_RST;
        e_q = wfv_pkg::E_RST;
        yplam_q = wfv_pkg::YPLAM_RST;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: zero flow (laminar, no viscosity), extremes, typical faces.
        rows = '{
            '{48'd0, 48'd0, QONE, QONE, 1'b0, 48'd0, 48'd0},
            '{48'd0, QONE, QONE, QONE, 1'b0, 48'd0, 48'd0},
            '{FULL, FULL, FULL, 48'd1, 1'b0, 48'd0, 48'd0},
            '{FULL, FULL, FULL, FULL, 1'b0, 48'd0, 48'd0},
            '{48'd1, 48'd1, 48'd1, FULL, 1'b0, 48'd0, 48'd0},
            '{QONE * 10, QONE / 100, QONE, QONE / 100000, 1'b0, 48'd0, 48'd0},
            '{QONE, QONE / 1000, QONE, QONE / 100000, 1'b0, 48'd0, 48'd0},
            '{QONE * 50, QONE / 10, QONE, QONE / 100000, 1'b0, 48'd0, 48'd0},
            '{QONE * 3, QONE / 10, QONE * 1000, QONE / 1000, 1'b0, 48'd0, 48'd0},
            '{48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA, 48'h1, 48'hFFFF, 1'b0, 48'd0, 48'd0}
        };
        foreach (rows[i])
        begin
            r = rows[i];
            send_face(r.u, r.y, r.rho, r.mu, {r.mut_exp, r.yp_exp}, r.known);
        end

        // Register extremes: zero, tiny and full laminar limit, zero, full and half E, zero and full kappa.
        wait_idle();
        write_reg(wfv_pkg::CFG_YPLAM, 48'd0);
        write_reg(wfv_pkg::CFG_E, 48'd0);
        write_reg(wfv_pkg::CFG_KAPPA, 48'd0);
        send_face(QONE, QONE, QONE, QONE, 96'd0, 1'b0);
        send_face(48'd0, 48'd0, 48'd1, 48'd1, 96'd0, 1'b0);
        wait_idle();
        write_reg(wfv_pkg::CFG_YPLAM, 48'd1);
        write_reg(wfv_pkg::CFG_E, FULL);
        write_reg(wfv_pkg::CFG_KAPPA, FULL);
        send_face(QONE, QONE, QONE, QONE, 96'd0, 1'b0);
        send_face(FULL, FULL, FULL, 48'd1, 96'd0, 1'b0);
        wait_idle();
        write_reg(wfv_pkg::CFG_YPLAM, FULL);
        write_reg(wfv_pkg::CFG_E, QONE / 2);
        send_face(QONE * 5, QONE, QONE, QONE / 1000, 96'd0, 1'b0);
        send_face(48'd0, 48'd0, 48'd1, 48'd1, 96'd0, 1'b0);

        // Random phases, each with its own register setting.
        for (int phase = 0; phase < 7; phase++)
        begin
            wait_idle();
            if (phase == 0)
            begin
                write_reg(wfv_pkg::CFG_KAPPA, wfv_pkg::KAPPA_RST);
                write_reg(wfv_pkg::CFG_E, wfv_pkg::E_RST);
                write_reg(wfv_pkg::CFG_YPLAM, wfv_pkg::YPLAM_RST);
            end
            else
            begin
                write_reg(wfv_pkg::CFG_KAPPA, ($urandom_range(0, 4) == 0) ? rand48() :
                          48'($urandom_range(0, 32'hFFFF_FFFF)));
                write_reg(wfv_pkg::CFG_E, ($urandom_range(0, 4) == 0) ? rand48() :
                          {16'($urandom_range(0, 30)), 32'($urandom)});
                write_reg(wfv_pkg::CFG_YPLAM, ($urandom_range(0, 4) == 0) ? rand48() :
                          {16'($urandom_range(0, 40)), 32'($urandom)});
            end
            quiet_stretch = (phase == 3);
            for (int n = 0; n < N_RANDOM / 7; n++)
            begin
                u = rand_field(1'b0);
                y = ($urandom_range(0, 3) == 0) ? rand_field(1'b0) :
                    48'($urandom_range(0, 32'hFFFF_FFFF));
                send_face(u, y, rand_field(1'b1), rand_field(1'b1), 96'd0, 1'b0);
            end
            quiet_stretch = 1'b0;
        end

        s_tvalid <= 1'b0;
        while (wall_results_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fails == 0 && wall_results_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> filelist.f
sv/wfv_pkg.sv
sv/wfv_alu.sv
sv/wall_function_turbulent_viscosity.sv
sim/wall_function_turbulent_viscosity_tb.sv
